>>> design/cow_page_allocator_refcount_core_macros.svh
// Assertion macros shared by the page allocator modules.
// Needs nothing else; the assertions compile away when SYNTHESIS is defined.
`ifndef COW_PAGE_ALLOCATOR_REFCOUNT_CORE_MACROS_SVH
`define COW_PAGE_ALLOCATOR_REFCOUNT_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define CPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> design/cpa_pkg.sv
// Shared types and codes for the copy-on-write page allocator.
// Used by cpa_ctrl, cpa_datapath, the top level, the checker and the testbench; depends on nothing.
package cpa_pkg;

    // Request operation codes; codes 5 to 7 act as a count read.
    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_FREE  = 3'd1;
    localparam logic [2:0] OP_INC   = 3'd2;
    localparam logic [2:0] OP_DEC   = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_RANGE = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    // Configuration register indexes.
    localparam logic REG_LOWEST = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    // Fixed field widths.
    localparam int PAGE_FIELD_W = 12;
    localparam int LIMIT_W      = 13;
    localparam int OUT_CNT_W    = 8;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 24;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic clr_en;   // write zero to the count table at the sweep address
        logic accept;   // take a request and start the table reads
        logic exec;     // finish the request and load the result register
    } cpa_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clr_last; // sweep address is at the last entry
        logic out_free; // result register can take a new result
    } cpa_sts_t;

endpackage

>>> design/cow_page_allocator_refcount_core.sv
// A request is accepted in the idle state; the execute state then loads the result
// register and m_tvalid. A new request is taken only after the previous one has
// completed, and the execute state waits while m_tready holds back an earlier result.
// The steps are the registered reads of the count table and free stack, then
// the read-modify-write of count table, stack and stack depth.
// Reset (rst_n, asynchronous) empties the stack, restores the bound registers
// and then sweeps every entry of the count table to zero, s_tready low.
`include "cow_page_allocator_refcount_core_macros.svh"

module cow_page_allocator_refcount_core #(
    parameter int NUM_PAGES  = 4096,
    parameter int COUNT_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Request stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cpa_pkg::IN_DATA_W-1:0]      s_tdata,   // op[2:0], page[14:3], zero[15]
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cpa_pkg::OUT_DATA_W-1:0]     m_tdata,   // page_out[11:0], ref_count[19:12],
                                                          // status[22:20], zero[23]
    // Configuration writes: index 0 lowest_page, index 1 limit_page.
    input  logic                               cfg_we,
    input  logic                               cfg_addr,
    input  logic [cpa_pkg::LIMIT_W-1:0]        cfg_wdata
);
    import cpa_pkg::*;

    // The controller only sequences; every table, counter and result
    // register lives in the datapath.
    cpa_cmd_t cmd;
    cpa_sts_t sts;

    logic [PAGE_FIELD_W-1:0] out_page;
    logic [OUT_CNT_W-1:0]    out_count;
    logic [2:0]              out_status;

    cpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The request fields are handed over unregistered; the datapath captures
    // them on the accept command and starts its memory reads in that cycle.
    cpa_datapath #(
        .NUM_PAGES  (NUM_PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tdata[2:0]),
        .in_page    (s_tdata[14:3]),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_page   (out_page),
        .out_count  (out_count),
        .out_status (out_status)
    );

    // Pack the result fields, page number in the lowest bits.
    assign m_tdata = {1'b0, out_status, out_count, out_page};

    `CPA_ASSERT(a_ready_idle_only, clk, rst_n,
        ((s_tready && s_tvalid) |-> cmd.accept),
        "request handshake without an accept command")
    `CPA_ASSERT_NEXT(a_exec_gives_result, clk, rst_n, cmd.exec, m_tvalid,
        "completed request produced no result")

endmodule

>>> design/cpa_ctrl.sv
// Sequencing state machine for the page allocator: clearing sweep, request
// intake and completion. Depends on cpa_pkg and the assertion macro header.
`include "cow_page_allocator_refcount_core_macros.svh"

module cpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cpa_pkg::cpa_sts_t sts,
    output cpa_pkg::cpa_cmd_t cmd
);
    import cpa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `CPA_ASSERT_NEXT(a_accept_then_exec, clk, rst_n, cmd.accept, state_reg == S_EXEC,
        "accepted request did not move to the execute state")
    `CPA_ASSERT(a_no_intake_while_clearing, clk, rst_n,
        (cmd.clr_en |-> (!in_ready && !cmd.accept && !cmd.exec)),
        "request taken during the clearing sweep")

endmodule

>>> design/cpa_datapath.sv
// Datapath of the page allocator: count table, free stack, stack depth,
// bound registers and result register. Depends on cpa_pkg and the macro header.
`include "cow_page_allocator_refcount_core_macros.svh"

module cpa_datapath #(
    parameter int NUM_PAGES  = 4096,
    parameter int COUNT_BITS = 8
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  cpa_pkg::cpa_cmd_t                        cmd,
    output cpa_pkg::cpa_sts_t                        sts,
    input  logic [2:0]                               in_op,
    input  logic [cpa_pkg::PAGE_FIELD_W-1:0]         in_page,
    input  logic                                     cfg_we,
    input  logic                                     cfg_addr,
    input  logic [cpa_pkg::LIMIT_W-1:0]              cfg_wdata,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [cpa_pkg::PAGE_FIELD_W-1:0]         out_page,
    output logic [cpa_pkg::OUT_CNT_W-1:0]            out_count,
    output logic [2:0]                               out_status
);
    import cpa_pkg::*;

    localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int TOP_W  = $clog2(NUM_PAGES + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    // Memories.
    logic [COUNT_BITS-1:0]   ref_mem [NUM_PAGES];
    logic [PAGE_FIELD_W-1:0] stk_mem [NUM_PAGES];

    // Control and bound registers.
    logic [TOP_W-1:0]        top_reg;
    logic [TOP_W-1:0]        top_next;
    logic [PAGE_W-1:0]       clr_cnt_reg;
    logic [PAGE_FIELD_W-1:0] lowest_reg;
    logic [LIMIT_W-1:0]      limit_reg;
    logic                    out_valid_reg;

    // Request and read data registers.
    logic [2:0]              op_reg;
    logic [PAGE_FIELD_W-1:0] page_reg;
    logic [COUNT_BITS-1:0]   ref_rd_reg;
    logic [PAGE_FIELD_W-1:0] stk_rd_reg;

    // Result register.
    logic [PAGE_FIELD_W-1:0] res_page_reg;
    logic [OUT_CNT_W-1:0]    res_cnt_reg;
    logic [2:0]              res_st_reg;

    // Execute-cycle logic.
    logic [TOP_W-1:0]        top_m1;
    logic [PAGE_FIELD_W-1:0] alloc_page;
    logic [PAGE_FIELD_W-1:0] res_page;
    logic [COUNT_BITS-1:0]   res_cnt;
    logic [2:0]              res_st;
    logic                    upd_we;
    logic [PAGE_W-1:0]       upd_addr;
    logic [COUNT_BITS-1:0]   upd_cnt;
    logic                    push;
    logic                    pop;
    logic                    ref_we;
    logic [PAGE_W-1:0]       ref_waddr;
    logic [COUNT_BITS-1:0]   ref_wdata;

    assign top_m1       = top_reg - TOP_W'(1);
    assign sts.clr_last = (clr_cnt_reg == PAGE_W'(NUM_PAGES - 1));
    assign sts.out_free = !out_valid_reg || out_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg <= '0;
            limit_reg  <= LIMIT_W'(4096);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LOWEST: lowest_reg <= cfg_wdata[PAGE_FIELD_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_wdata;
                default:    limit_reg  <= limit_reg;
            endcase
        end
    end

    // Sweep counter for clearing the count table after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + PAGE_W'(1);
        end
    end

    // Request capture; the table reads are launched in the same cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= in_op;
            page_reg <= in_page;
        end
    end

    // Operation decode and saturating count update.
    always_comb
    begin
        alloc_page = (32'(stk_rd_reg) >= NUM_PAGES) ? '0 : stk_rd_reg;
        res_page   = page_reg;
        res_cnt    = ref_rd_reg;
        res_st     = ST_OK;
        upd_we     = 1'b0;
        upd_addr   = PAGE_W'(page_reg);
        upd_cnt    = ref_rd_reg;
        push       = 1'b0;
        pop        = 1'b0;
        if (op_reg == OP_ALLOC)
        begin
            if (top_reg == '0)
            begin
                res_page = '0;
                res_cnt  = '0;
                res_st   = ST_EMPTY;
            end
            else
            begin
                pop      = 1'b1;
                res_page = alloc_page;
                res_cnt  = CNT_ONE;
                upd_we   = 1'b1;
                upd_addr = PAGE_W'(alloc_page);
                upd_cnt  = CNT_ONE;
            end
        end
        else if (32'(page_reg) >= NUM_PAGES)
        begin
            res_cnt = '0;
            res_st  = ST_RANGE;
        end
        else
        begin
            case (op_reg)
                OP_FREE:
                begin
                    if ((page_reg < lowest_reg) || ({1'b0, page_reg} >= limit_reg))
                    begin
                        res_st = ST_RANGE;
                    end
                    else if (ref_rd_reg > CNT_ONE)
                    begin
                        res_cnt = ref_rd_reg - CNT_ONE;
                        upd_we  = 1'b1;
                        upd_cnt = res_cnt;
                    end
                    else if (32'(top_reg) >= NUM_PAGES)
                    begin
                        res_st = ST_FULL;
                    end
                    else
                    begin
                        res_cnt = '0;
                        upd_we  = 1'b1;
                        upd_cnt = '0;
                        push    = 1'b1;
                    end
                end
                OP_INC:
                begin
                    if (ref_rd_reg == CNT_MAX)
                    begin
                        res_st = ST_SAT;
                    end
                    else
                    begin
                        res_cnt = ref_rd_reg + CNT_ONE;
                        upd_we  = 1'b1;
                        upd_cnt = res_cnt;
                    end
                end
                OP_DEC:
                begin
                    if (ref_rd_reg == '0)
                    begin
                        res_st = ST_SAT;
                    end
                    else
                    begin
                        res_cnt = ref_rd_reg - CNT_ONE;
                        upd_we  = 1'b1;
                        upd_cnt = res_cnt;
                    end
                end
                default:
                begin
                    res_st = ST_OK;
                end
            endcase
        end
    end

    // Count table write port: clearing sweep or request update.
    always_comb
    begin
        ref_we    = cmd.clr_en || (cmd.exec && upd_we);
        ref_waddr = cmd.clr_en ? clr_cnt_reg : upd_addr;
        ref_wdata = cmd.clr_en ? '0 : upd_cnt;
    end

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_waddr] <= ref_wdata;
        end
        if (cmd.accept)
        begin
            ref_rd_reg <= ref_mem[PAGE_W'(in_page)];
        end
    end

    // Free stack: push at the depth, pop reads the entry below it.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push)
        begin
            stk_mem[top_reg[PAGE_W-1:0]] <= page_reg;
        end
        if (cmd.accept)
        begin
            stk_rd_reg <= stk_mem[top_m1[PAGE_W-1:0]];
        end
    end

    always_comb
    begin
        top_next = top_reg;
        if (cmd.exec && push)
        begin
            top_next = top_reg + TOP_W'(1);
        end
        else if (cmd.exec && pop)
        begin
            top_next = top_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else
        begin
            top_reg <= top_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_page_reg <= res_page;
            res_cnt_reg  <= OUT_CNT_W'(res_cnt);
            res_st_reg   <= res_st;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_page   = res_page_reg;
    assign out_count  = res_cnt_reg;
    assign out_status = res_st_reg;

    `CPA_ASSERT(a_load_only_when_free, clk, rst_n,
        (cmd.exec |-> (!out_valid_reg || out_ready)),
        "result register loaded while holding an untaken result")
    `CPA_ASSERT(a_depth_moves_on_exec, clk, rst_n,
        (!$past(cmd.exec) |-> $stable(top_reg)),
        "stack depth changed outside a request completion")
    `CPA_ASSERT(a_depth_bounded, clk, rst_n,
        ((cmd.exec && push) |-> (32'(top_reg) < NUM_PAGES)),
        "push onto a full free stack")

endmodule

>>> verif/cpa_result_checker.sv
`timescale 1ns / 100ps
// Checker for the copy-on-write page allocator: watches the request, result and
// register ports, keeps its own copy of stack, counts and bounds, and compares.
// Depends on cpa_pkg for codes and field widths.
module cpa_result_checker
    import cpa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [IN_DATA_W-1:0]    s_tdata,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_DATA_W-1:0]   m_tdata,
    input  logic                    cfg_we,
    input  logic                    cfg_addr,
    input  logic [LIMIT_W-1:0]      cfg_wdata,
    output int                      error_total,
    output int                      results_outstanding
);

    localparam int PAGE_COUNT  = 4096;
    localparam int PRINT_LIMIT = 100;
    localparam logic [OUT_CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [PAGE_FIELD_W-1:0] page;
        logic [OUT_CNT_W-1:0]    ref_count;
        logic [2:0]              status;
    } page_result_t;

    logic [PAGE_FIELD_W-1:0] free_pages [PAGE_COUNT];
    logic [OUT_CNT_W-1:0]    page_counts [PAGE_COUNT];
    int                      stack_depth;
    logic [PAGE_FIELD_W-1:0] lowest_bound;
    logic [LIMIT_W-1:0]      limit_bound;
    page_result_t            pending_results [$];

    // Applies one request to the local copy of the allocator state and returns
    // the result the block should produce for it.
    function automatic page_result_t advance_page_state(input logic [2:0] op,
                                                        input logic [PAGE_FIELD_W-1:0] pg);
        page_result_t            res;
        logic [OUT_CNT_W-1:0]    cnt;
        logic [PAGE_FIELD_W-1:0] popped;
        cnt = page_counts[pg];
        res.page = pg;
        res.ref_count = cnt;
        res.status = ST_OK;
        case (op)
            OP_ALLOC:
            begin
                if (stack_depth == 0)
                begin
                    res.page = '0;
                    res.ref_count = '0;
                    res.status = ST_EMPTY;
                end
                else
                begin
                    stack_depth--;
                    popped = free_pages[stack_depth];
                    page_counts[popped] = OUT_CNT_W'(1);
                    res.page = popped;
                    res.ref_count = OUT_CNT_W'(1);
                end
            end
            OP_FREE:
            begin
                if (pg < lowest_bound || {1'b0, pg} >= limit_bound)
                    res.status = ST_RANGE;
                else if (cnt > 1)
                begin
                    page_counts[pg] = cnt - 1'b1;
                    res.ref_count = cnt - 1'b1;
                end
                else if (stack_depth >= PAGE_COUNT)
                    res.status = ST_FULL;
                else
                begin
                    page_counts[pg] = '0;
                    free_pages[stack_depth] = pg;
                    stack_depth++;
                    res.ref_count = '0;
                end
            end
            OP_INC:
            begin
                if (cnt == COUNT_MAX)
                    res.status = ST_SAT;
                else
                begin
                    page_counts[pg] = cnt + 1'b1;
                    res.ref_count = cnt + 1'b1;
                end
            end
            OP_DEC:
            begin
                if (cnt == 0)
                    res.status = ST_SAT;
                else
                begin
                    page_counts[pg] = cnt - 1'b1;
                    res.ref_count = cnt - 1'b1;
                end
            end
            default:
            begin
                // Count reads and the spare op codes leave the state alone.
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        // Printing stops after a while so a broken block cannot flood the log.
        if (error_total < PRINT_LIMIT)
            $display("%0t: MISMATCH %s", $time, msg);
        error_total++;
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] beat);
        page_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result for page %0d with no request outstanding",
                                      beat[11:0]));
            return;
        end
        want = pending_results.pop_front();
        if (beat[11:0] !== want.page)
            report_mismatch($sformatf("page_out got %0d expected %0d", beat[11:0], want.page));
        if (beat[19:12] !== want.ref_count)
            report_mismatch($sformatf("ref_count for page %0d got %0d expected %0d",
                                      want.page, beat[19:12], want.ref_count));
        if (beat[22:20] !== want.status)
            report_mismatch($sformatf("status for page %0d got %0d expected %0d",
                                      want.page, beat[22:20], want.status));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAGE_COUNT; i++)
                page_counts[i] = '0;
            stack_depth = 0;
            lowest_bound = '0;
            limit_bound = 13'd4096;
            pending_results.delete();
            error_total = 0;
            results_outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_LOWEST)
                    lowest_bound = cfg_wdata[PAGE_FIELD_W-1:0];
                else
                    limit_bound = cfg_wdata;
            end
            // A result always belongs to an older request, so it is checked first.
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                pending_results.push_back(advance_page_state(s_tdata[2:0], s_tdata[14:3]));
            results_outstanding <= pending_results.size();
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Top of the page allocator testbench: clock, reset, request and register
// stimulus, result back-pressure and the verdict. Needs cpa_pkg, the allocator
// core and cpa_result_checker.
module testbench;
    import cpa_pkg::*;

    // Op codes 5 to 7 are not assigned and must behave as a count read.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_MID   = 3'd6;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    // Cycles to let pass after the last result before a register write or the end.
    localparam int DRAIN_CYCLES  = 4;
    localparam int PHASE_COUNT   = 6;
    localparam int PHASE_LENGTH  = 235;
    localparam logic [PAGE_FIELD_W-1:0] TOP_PAGE = 12'd4095;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;     // op[2:0], page[14:3], zero[15]
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;     // page_out[11:0], ref_count[19:12], status[22:20]
    logic                    cfg_we;
    logic                    cfg_addr;
    logic [LIMIT_W-1:0]      cfg_wdata;
    int                      error_total;
    int                      results_outstanding;
    int                      no_gap_left;

    cow_page_allocator_refcount_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // The checker watches every channel and does all prediction and comparison.
    cpa_result_checker result_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .cfg_we              (cfg_we),
        .cfg_addr            (cfg_addr),
        .cfg_wdata           (cfg_wdata),
        .error_total         (error_total),
        .results_outstanding (results_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap before the next request. Most gaps are short, a few are long, and now
    // and then a burst of back-to-back requests keeps s_tvalid high throughout.
    function automatic int next_gap();
        int roll;
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            no_gap_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Presents one request and returns at the edge that accepts it. s_tvalid is
    // left high, so a following request with no gap goes out back to back; it
    // is only lowered when a gap or the idle wait follows.
    task automatic send_request(input logic [2:0] op, input logic [PAGE_FIELD_W-1:0] pg);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, pg, op};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stops sending and waits until every expected result has come back, plus
    // the block's latency, so that the block is idle for a register write.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes both bound registers, the lowest bound first and then the limit.
    task automatic write_bounds(input logic [LIMIT_W-1:0] lowest, input logic [LIMIT_W-1:0] limit);
        cfg_we <= 1'b1;
        cfg_addr <= REG_LOWEST;
        cfg_wdata <= lowest;
        @(posedge clk);
        cfg_addr <= REG_LIMIT;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Result side back-pressure: runs of ready, sometimes long enough to give
    // stall-free stretches, broken by stalls that are mostly short.
    initial
    begin
        int run;
        int stall;
        int roll;
        m_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                run = $urandom_range(1, 4);
            else if (roll < 85)
                run = $urandom_range(5, 20);
            else
                run = $urandom_range(40, 120);
            m_tready <= 1'b1;
            repeat (run) @(posedge clk);
            roll = $urandom_range(0, 99);
            if (roll < 40)
                stall = 0;
            else if (roll < 85)
                stall = $urandom_range(1, 3);
            else if (roll < 97)
                stall = $urandom_range(4, 10);
            else
                stall = $urandom_range(11, 30);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [LIMIT_W-1:0]      phase_lowest [PHASE_COUNT];
        logic [LIMIT_W-1:0]      phase_limit [PHASE_COUNT];
        logic [PAGE_FIELD_W-1:0] window_base;
        logic [PAGE_FIELD_W-1:0] pg;
        logic [2:0]              op;
        int                      roll;
        int                      span;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = REG_LOWEST;
        cfg_wdata = '0;
        no_gap_left = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening. The block sweeps its count table after reset with
        // s_tready low, so the first request simply waits for that to finish.
        // Allocate on an empty stack, reads at both ends of the page range and
        // a decrement of a zero count come first.
        send_request(OP_ALLOC, 12'd0);
        send_request(OP_READ, 12'd0);
        send_request(OP_READ, TOP_PAGE);
        send_request(OP_DEC, 12'd5);
        // Fill the pool with the two extreme pages, then take them back; the
        // stack is LIFO, so the highest page comes out first.
        send_request(OP_FREE, 12'd0);
        send_request(OP_FREE, TOP_PAGE);
        send_request(OP_ALLOC, 12'h555);
        send_request(OP_ALLOC, 12'hAAA);
        // A shared page: a second reference, a free that only drops the count,
        // a free that returns the page, and a repeated free that pushes it again.
        send_request(OP_INC, 12'd0);
        send_request(OP_FREE, 12'd0);
        send_request(OP_FREE, 12'd0);
        send_request(OP_FREE, 12'd0);
        send_request(OP_DEC, TOP_PAGE);
        // Spare op codes must act as reads.
        send_request(OP_SPARE_FIRST, 12'hAAA);
        send_request(OP_SPARE_MID, 12'h555);
        send_request(OP_SPARE_LAST, TOP_PAGE);

        // Narrow bounds: free is rejected just outside them and accepted at the
        // edges inside them.
        wait_until_idle();
        write_bounds(13'd100, 13'd200);
        send_request(OP_FREE, 12'd99);
        send_request(OP_FREE, 12'd200);
        send_request(OP_FREE, 12'd100);
        send_request(OP_FREE, 12'd199);
        send_request(OP_INC, 12'd99);
        send_request(OP_READ, 12'd99);

        // Random phases, each under its own bound setting. The extremes come
        // first: the whole range, only the top page, only page zero, then a
        // random window, an inverted pair that rejects every free, and another
        // random window.
        phase_lowest[0] = 13'd0;
        phase_limit[0] = 13'd4096;
        phase_lowest[1] = 13'd4095;
        phase_limit[1] = 13'd4096;
        phase_lowest[2] = 13'd0;
        phase_limit[2] = 13'd1;
        phase_lowest[3] = LIMIT_W'($urandom_range(0, 2047));
        phase_limit[3] = LIMIT_W'($urandom_range(2048, 4096));
        phase_lowest[4] = LIMIT_W'($urandom_range(2048, 4095));
        phase_limit[4] = LIMIT_W'($urandom_range(1, 2047));
        phase_lowest[5] = LIMIT_W'($urandom_range(0, 4000));
        phase_limit[5] = LIMIT_W'(phase_lowest[5] + $urandom_range(1, 96));

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            wait_until_idle();
            write_bounds(phase_lowest[ph], phase_limit[ph]);
            // Most requests go to a window of 16 pages starting inside the free bounds,
            // so pages get freed, allocated again and shared repeatedly; the
            // rest use any page to cover every page bit and range rejection.
            if (phase_limit[ph] > phase_lowest[ph])
            begin
                span = int'(phase_limit[ph]) - int'(phase_lowest[ph]);
                window_base = PAGE_FIELD_W'(phase_lowest[ph] + $urandom_range(0, span - 1));
            end
            else
                window_base = PAGE_FIELD_W'($urandom_range(0, TOP_PAGE));
            for (int n = 0; n < PHASE_LENGTH; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 22)
                    op = OP_ALLOC;
                else if (roll < 52)
                    op = OP_FREE;
                else if (roll < 70)
                    op = OP_INC;
                else if (roll < 84)
                    op = OP_DEC;
                else if (roll < 94)
                    op = OP_READ;
                else
                    op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
                if ($urandom_range(0, 99) < 75)
                    pg = PAGE_FIELD_W'(window_base + $urandom_range(0, 15));
                else
                    pg = PAGE_FIELD_W'($urandom_range(0, TOP_PAGE));
                send_request(op, pg);
            end
        end

        // Saturation of one count: enough increments to reach the maximum from
        // any starting count and bump into it, then enough decrements to reach
        // zero and bump into that.
        pg = PAGE_FIELD_W'($urandom_range(0, TOP_PAGE));
        repeat (257) send_request(OP_INC, pg);
        repeat (257) send_request(OP_DEC, pg);

        // Refill under the full bounds: a page with a count of one or less is
        // pushed on every free, so freeing one page several times stacks it
        // repeatedly. A few allocations and reads follow.
        wait_until_idle();
        write_bounds(13'd0, 13'd4096);
        pg = PAGE_FIELD_W'($urandom_range(0, TOP_PAGE));
        repeat (8) send_request(OP_FREE, pg);
        repeat (3) send_request(OP_ALLOC, 12'd0);
        send_request(OP_READ, pg);
        send_request(OP_FREE, pg);
        send_request(OP_FREE, pg);

        wait_until_idle();
        if (error_total == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit, far above the slowest correct run including the clearing
    // sweep after reset.
    initial
    begin
        #25_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/cpa_pkg.sv
design/cpa_ctrl.sv
design/cpa_datapath.sv
design/cow_page_allocator_refcount_core.sv
verif/cpa_result_checker.sv
verif/testbench.sv
